@@ hw/rtl/isk5_pkg.sv @@
// Package for the five-vertex independent set search block.
// Holds the request and response word types and fixed field widths.
// No dependencies.
`default_nettype none

package isk5_pkg;

   localparam int EDGES_LOW_W  = 64;
   localparam int EDGES_HIGH_W = 14;
   localparam int EDGE_BITS    = EDGES_LOW_W + EDGES_HIGH_W;
   localparam int MASK_W       = 13;

   typedef struct packed {
      logic [EDGES_LOW_W-1:0]  edges_low;
      logic [EDGES_HIGH_W-1:0] edges_high;
   } isk5_req_type;

   typedef struct packed {
      logic              found;
      logic [MASK_W-1:0] set_mask;
   } isk5_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/independent_set_search_k5.sv @@
// Top level of the independent set search: adjacency build, search sequencer, step unit.
// Depends on isk5_pkg for the request and response word types.
//
// Takes one graph word when start is high and busy is low, then searches depth first for
// the lexicographically first independent set of SET_SIZE vertices. The adjacency rows load
// at the edge that takes the graph; after that a single step unit runs the search, where a
// step either picks the lowest remaining candidate at the current depth or backs up one
// level, ending with no set found when depth zero has too few candidates. Busy stays high
// while the steps run, and the result word follows in the cycle after the last step. The
// result word appears on rsp_word with rsp_strobe high for exactly one cycle; the receiver
// cannot stall it, and a new graph may be started in that same cycle.
`default_nettype none

module independent_set_search_k5 #(
   parameter int VERTICES = 13,
   parameter int SET_SIZE = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire isk5_pkg::isk5_req_type req_word,
   output logic                        rsp_strobe,
   output isk5_pkg::isk5_rsp_type      rsp_word
);
   import isk5_pkg::*;

   localparam int DEPTH_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int CNT_W   = $clog2(VERTICES + 1);
   localparam int SUM_W   = $clog2(VERTICES + SET_SIZE + 1);

   typedef logic [VERTICES-1:0] row_type;
   typedef enum logic [0:0] {ST_IDLE, ST_SEARCH} state_type;

   state_type           state_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [DEPTH_W-1:0]  depth_in;
   row_type             adj_ff  [VERTICES];
   row_type             cand_ff [SET_SIZE];
   row_type             base_ff [SET_SIZE];
   logic                rsp_strobe_ff;
   isk5_rsp_type        rsp_word_ff;

   logic [EDGE_BITS-1:0] edge_vec;
   row_type              adj_build [VERTICES];
   row_type              cand_cur;
   row_type              base_cur;
   row_type              pick;
   row_type              rest;
   row_type              pick_row;
   logic [CNT_W-1:0]     cand_cnt;
   logic                 viable;
   logic                 last_level;

   function automatic logic [CNT_W-1:0] count_ones(input row_type x);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < VERTICES; k++) begin
         n = n + CNT_W'(x[k]);
      end
      return n;
   endfunction

   assign edge_vec = {req_word.edges_high, req_word.edges_low};

   always_comb begin
      for (int v = 0; v < VERTICES; v++) begin
         adj_build[v] = '0;
      end
      for (int j = 1; j < VERTICES; j++) begin
         for (int i = 0; i < j; i++) begin
            if (edge_vec[j * (j - 1) / 2 + i]) begin
               adj_build[i][j] = 1'b1;
               adj_build[j][i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cand_cur   = cand_ff[depth_ff];
      base_cur   = base_ff[depth_ff];
      cand_cnt   = count_ones(cand_cur);
      viable     = (SUM_W'(cand_cnt) + SUM_W'(depth_ff)) >= SUM_W'(SET_SIZE);
      pick       = cand_cur & (~cand_cur + row_type'(1));
      rest       = cand_cur & ~pick;
      last_level = depth_ff == DEPTH_W'(SET_SIZE - 1);
      depth_in   = depth_ff + DEPTH_W'(1);
      pick_row   = '0;
      for (int v = 0; v < VERTICES; v++) begin
         if (pick[v]) begin
            pick_row = pick_row | adj_ff[v];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (start) begin
                  adj_ff     <= adj_build;
                  cand_ff[0] <= '1;
                  base_ff[0] <= '0;
                  depth_ff   <= '0;
                  state_ff   <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (viable) begin
                  cand_ff[depth_ff] <= rest;
                  if (last_level) begin
                     rsp_strobe_ff        <= 1'b1;
                     rsp_word_ff.found    <= 1'b1;
                     rsp_word_ff.set_mask <= MASK_W'(base_cur | pick);
                     state_ff             <= ST_IDLE;
                  end else begin
                     rsp_strobe_ff     <= 1'b0;
                     cand_ff[depth_in] <= rest & ~pick_row;
                     base_ff[depth_in] <= base_cur | pick;
                     depth_ff          <= depth_in;
                  end
               end else if (depth_ff == '0) begin
                  rsp_strobe_ff        <= 1'b1;
                  rsp_word_ff.found    <= 1'b0;
                  rsp_word_ff.set_mask <= '0;
                  state_ff             <= ST_IDLE;
               end else begin
                  rsp_strobe_ff <= 1'b0;
                  depth_ff      <= depth_ff - DEPTH_W'(1);
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_miss_mask_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.found |-> rsp_word.set_mask == '0)
      else $error("nonzero mask with no set found");

   a_hit_size: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.found |-> $countones(rsp_word.set_mask) == SET_SIZE)
      else $error("found set has wrong size");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted graph did not start a search");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> depth_ff < DEPTH_W'(SET_SIZE))
      else $error("search depth out of range");

endmodule

`default_nettype wire
